FILE: design/srse_pkg.sv
// Shared types and constants of the scanline run span extractor.
// No dependencies; every other file of the block refers to this package.
package srse_pkg;

  // Screen and colour limits
  localparam int ScreenWidth = 1024;
  localparam int MaxStretch  = 8;
  localparam int ColorCount  = 8;
  localparam int MaxRepeat   = 8;
  localparam int QueueDepth  = 4;

  // Field widths
  localparam int XW   = 10;
  localparam int YW   = 10;
  localparam int CW   = 3;
  localparam int SW   = 4;
  localparam int IdxW = 3;

  localparam logic [YW-1:0] YMax = '1;

  // Register indexes of the configuration port
  typedef enum logic [IdxW-1:0] {
    REG_BACKGROUND_COLOR = 3'd0,
    REG_STRETCH_X        = 3'd1,
    REG_REPEAT_Y         = 3'd2,
    REG_ROW_FIRST_X      = 3'd3,
    REG_ROW_LAST_X       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CW-1:0] background_color;
    logic [SW-1:0] stretch_x;
    logic [SW-1:0] repeat_y;
    logic [XW-1:0] row_first_x;
    logic [XW-1:0] row_last_x;
  } cfg_t;

  // One finished run to be drawn
  typedef struct packed {
    logic          valid;
    logic [XW-1:0] first_x;
    logic [XW-1:0] last_x;
    logic [CW-1:0] color;
  } run_t;

  // Work for one pixel: a run closed by a colour change, then one closed by row end
  typedef struct packed {
    run_t          run_a;
    run_t          run_b;
    logic [YW-1:0] row_y;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: design/srse_pix_if.sv
// Pixel request channel of the scanline run span extractor.
// Depends on srse_pkg for field widths.
interface srse_pix_if;
  logic                     valid;
  logic                     ready;
  logic [srse_pkg::CW-1:0]  pixel_color;
  logic [srse_pkg::YW-1:0]  row_y;

  modport source (output valid, pixel_color, row_y, input ready);
  modport sink   (input valid, pixel_color, row_y, output ready);
endinterface

FILE: design/srse_span_if.sv
// Span request channel of the scanline run span extractor.
// Depends on srse_pkg for field widths.
interface srse_span_if;
  logic                     valid;
  logic                     ready;
  logic [srse_pkg::XW-1:0]  span_first_x;
  logic [srse_pkg::XW-1:0]  span_last_x;
  logic [srse_pkg::YW-1:0]  span_y;
  logic [srse_pkg::CW-1:0]  span_color;
  logic                     last_of_item;

  modport source (output valid, span_first_x, span_last_x, span_y, span_color,
                  last_of_item, input ready);
  modport sink   (input valid, span_first_x, span_last_x, span_y, span_color,
                  last_of_item, output ready);
endinterface

FILE: design/srse_cfg_if.sv
// Configuration write channel of the scanline run span extractor.
// Depends on srse_pkg for index and data widths.
interface srse_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [srse_pkg::IdxW-1:0]  index;
  logic [srse_pkg::XW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/scanline_run_span_extractor_core.sv
// Top level of the scanline run span extractor: config registers, front, queue, back.
// Depends on srse_pkg, the three channel interfaces, srse_front, srse_queue, srse_back.
//
//   channel   dir   payload                                           
//   pix_i     in    pixel_color[2:0], row_y[9:0]                      
//   span_o    out   span_first_x, span_last_x, span_y, span_color, last_of_item
//   cfg_i     in    index[2:0], data[9:0], always ready               
//
// The front end takes one pixel per cycle while the work queue has room.
// Each drawn run yields repeat_y spans (clamped to 1..8) in the back end, one span
// per cycle while the span output is not stalled; a pixel ending two runs yields twice
// that. A first span passes the queue, the back end's entry register and the span
// output register. Reset clears all control state asynchronously; no clearing pass.
// A stalled span output holds the back end; the queue then fills and pixel ready drops.
module scanline_run_span_extractor_core #(
  parameter int QueueDepth = srse_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srse_pix_if.sink    pix_i,
  srse_span_if.source span_o,
  srse_cfg_if.sink    cfg_i
);

  srse_pkg::cfg_t    cfg_q;
  srse_pkg::q_stat_t q_stat;
  srse_pkg::entry_t  push_entry, head_entry;
  logic              q_push, q_pop;

  // Write configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.background_color <= '0;
      cfg_q.stretch_x        <= srse_pkg::SW'(1);
      cfg_q.repeat_y         <= srse_pkg::SW'(1);
      cfg_q.row_first_x      <= '0;
      cfg_q.row_last_x       <= '1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (srse_pkg::cfg_reg_e'(cfg_i.index))
        srse_pkg::REG_BACKGROUND_COLOR: cfg_q.background_color <= cfg_i.data[srse_pkg::CW-1:0];
        srse_pkg::REG_STRETCH_X:        cfg_q.stretch_x        <= cfg_i.data[srse_pkg::SW-1:0];
        srse_pkg::REG_REPEAT_Y:         cfg_q.repeat_y         <= cfg_i.data[srse_pkg::SW-1:0];
        srse_pkg::REG_ROW_FIRST_X:      cfg_q.row_first_x      <= cfg_i.data;
        srse_pkg::REG_ROW_LAST_X:       cfg_q.row_last_x       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  srse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .pix_i    (pix_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .entry_o  (push_entry)
  );

  srse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  srse_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .entry_i  (head_entry),
    .pop_o    (q_pop),
    .span_o   (span_o)
  );

`ifndef SYNTH
  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_stat.full))
    else $error("push into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_stat.empty))
    else $error("pop from empty queue");

  // Spans never run backwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   span_o.valid |-> (span_o.span_first_x <= span_o.span_last_x))
    else $error("span with first column after last column");
`endif

endmodule

FILE: design/srse_front.sv
// Front end: accepts pixels, tracks the current run and classifies run ends.
// Depends on srse_pkg and srse_pix_if; pushes work entries into srse_queue.
module srse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srse_pkg::cfg_t    cfg_i,
  srse_pix_if.sink          pix_i,
  input  srse_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output srse_pkg::entry_t  entry_o
);

  logic [srse_pkg::XW:0]    next_x_q, next_x_d;
  logic [srse_pkg::XW-1:0]  run_start_q, run_start_d;
  logic [srse_pkg::CW-1:0]  run_color_q, run_color_d;
  logic                     run_open_q, run_open_d;

  logic                     accept;
  logic [srse_pkg::CW-1:0]  color_eff;
  logic [srse_pkg::XW-1:0]  last_x;
  logic [srse_pkg::SW:0]    stretch;
  logic                     drop;
  logic [srse_pkg::XW-1:0]  x0;
  logic [srse_pkg::XW+1:0]  x1_sum;
  logic [srse_pkg::XW-1:0]  x1;
  logic                     change;
  logic                     keep;
  logic [srse_pkg::XW-1:0]  start_m;
  logic [srse_pkg::CW-1:0]  color_m;
  logic                     row_end;

  // Take a pixel whenever the queue has room
  assign pix_i.ready = !q_stat_i.full;
  assign accept      = pix_i.valid && pix_i.ready;

  // Clamp inputs and registers to legal ranges
  always_comb begin
    if (int'(pix_i.pixel_color) >= srse_pkg::ColorCount) begin
      color_eff = cfg_i.background_color;
    end else begin
      color_eff = pix_i.pixel_color;
    end
    if (int'(cfg_i.row_last_x) > srse_pkg::ScreenWidth - 1) begin
      last_x = srse_pkg::XW'(srse_pkg::ScreenWidth - 1);
    end else begin
      last_x = cfg_i.row_last_x;
    end
    stretch = {1'b0, cfg_i.stretch_x};
    if (stretch == '0) begin
      stretch = (srse_pkg::SW+1)'(1);
    end
    if (int'(stretch) > srse_pkg::MaxStretch) begin
      stretch = (srse_pkg::SW+1)'(srse_pkg::MaxStretch);
    end
  end

  // Place the stretched pixel and classify run ends
  always_comb begin
    drop   = next_x_q > {1'b0, last_x};
    x0     = next_x_q[srse_pkg::XW-1:0];
    x1_sum = {1'b0, next_x_q} + (srse_pkg::XW+2)'(stretch) - (srse_pkg::XW+2)'(1);
    if (x1_sum > (srse_pkg::XW+2)'(last_x)) begin
      x1 = last_x;
    end else begin
      x1 = x1_sum[srse_pkg::XW-1:0];
    end
    change  = run_open_q && (color_eff != run_color_q);
    keep    = run_open_q && !change;
    start_m = keep ? run_start_q : x0;
    color_m = keep ? run_color_q : color_eff;
    row_end = (x1 == last_x);

    entry_o.run_a.valid   = change && (run_color_q != cfg_i.background_color);
    entry_o.run_a.first_x = run_start_q;
    entry_o.run_a.last_x  = x0 - srse_pkg::XW'(1);
    entry_o.run_a.color   = run_color_q;
    entry_o.run_b.valid   = row_end && (color_m != cfg_i.background_color);
    entry_o.run_b.first_x = start_m;
    entry_o.run_b.last_x  = last_x;
    entry_o.run_b.color   = color_m;
    entry_o.row_y         = pix_i.row_y;

    push_o = accept && !drop && (entry_o.run_a.valid || entry_o.run_b.valid);
  end

  // Advance run state on each accepted pixel
  always_comb begin
    next_x_d    = next_x_q;
    run_start_d = run_start_q;
    run_color_d = run_color_q;
    run_open_d  = run_open_q;
    if (accept) begin
      priority if (drop) begin
        next_x_d    = {1'b0, cfg_i.row_first_x};
        run_start_d = cfg_i.row_first_x;
        run_open_d  = 1'b0;
      end else if (row_end) begin
        next_x_d    = {1'b0, cfg_i.row_first_x};
        run_start_d = cfg_i.row_first_x;
        run_color_d = color_m;
        run_open_d  = 1'b0;
      end else begin
        next_x_d    = {1'b0, x1} + (srse_pkg::XW+1)'(1);
        run_start_d = start_m;
        run_color_d = color_m;
        run_open_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_x_q    <= '0;
      run_start_q <= '0;
      run_color_q <= '0;
      run_open_q  <= 1'b0;
    end else begin
      next_x_q    <= next_x_d;
      run_start_q <= run_start_d;
      run_color_q <= run_color_d;
      run_open_q  <= run_open_d;
    end
  end

endmodule

FILE: design/srse_queue.sv
// Short work queue between front and back end.
// Depends on srse_pkg for the entry and status types.
module srse_queue #(
  parameter int Depth = srse_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  srse_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output srse_pkg::entry_t  entry_o,
  output srse_pkg::q_stat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  srse_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign entry_o      = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/srse_back.sv
// Back end: expands queued runs into one span per row of vertical repeat.
// Depends on srse_pkg and srse_span_if; pops entries from srse_queue.
module srse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srse_pkg::cfg_t    cfg_i,
  input  srse_pkg::q_stat_t q_stat_i,
  input  srse_pkg::entry_t  entry_i,
  output logic              pop_o,
  srse_span_if.source       span_o
);

  logic                     busy_q, busy_d;
  logic                     phase_b_q, phase_b_d;
  logic [2:0]               rep_q, rep_d;
  srse_pkg::entry_t         ent_q, ent_d;
  logic                     out_valid_q, out_valid_d;
  logic [srse_pkg::XW-1:0]  out_first_q, out_last_q;
  logic [srse_pkg::YW-1:0]  out_y_q;
  logic [srse_pkg::CW-1:0]  out_color_q;
  logic                     out_lst_q;

  logic [srse_pkg::SW-1:0]  reps;
  logic [2:0]               last_rep;
  srse_pkg::run_t           cur;
  logic                     adv, emit, final_rep, item_done, load;
  logic [srse_pkg::YW:0]    y_sum;
  logic [srse_pkg::YW-1:0]  y_sat;

  // Clamp repeat count
  always_comb begin
    reps = cfg_i.repeat_y;
    if (reps == '0) begin
      reps = srse_pkg::SW'(1);
    end
    if (int'(reps) > srse_pkg::MaxRepeat) begin
      reps = srse_pkg::SW'(srse_pkg::MaxRepeat);
    end
    last_rep = 3'(reps - srse_pkg::SW'(1));
  end

  // Pick the run and row for this cycle
  always_comb begin
    cur       = phase_b_q ? ent_q.run_b : ent_q.run_a;
    adv       = !out_valid_q || span_o.ready;
    emit      = busy_q && adv;
    final_rep = (rep_q == last_rep);
    item_done = emit && final_rep && (phase_b_q || !ent_q.run_b.valid);
    load      = !q_stat_i.empty && (!busy_q || item_done);
    pop_o     = load;
    y_sum     = {1'b0, ent_q.row_y} + (srse_pkg::YW+1)'(rep_q);
    y_sat     = (y_sum > {1'b0, srse_pkg::YMax}) ? srse_pkg::YMax
                                                 : y_sum[srse_pkg::YW-1:0];
  end

  // Step through repeats and runs, then load the next entry
  always_comb begin
    busy_d      = busy_q;
    phase_b_d   = phase_b_q;
    rep_d       = rep_q;
    ent_d       = ent_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (final_rep) begin
        rep_d = '0;
        if (!phase_b_q && ent_q.run_b.valid) begin
          phase_b_d = 1'b1;
        end else begin
          busy_d = 1'b0;
        end
      end else begin
        rep_d = rep_q + 3'd1;
      end
    end else if (span_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d    = 1'b1;
      ent_d     = entry_i;
      phase_b_d = !entry_i.run_a.valid;
      rep_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_b_q   <= 1'b0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_b_q   <= phase_b_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold entry and span payload
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (emit) begin
      out_first_q <= cur.first_x;
      out_last_q  <= cur.last_x;
      out_y_q     <= y_sat;
      out_color_q <= cur.color;
      out_lst_q   <= item_done;
    end
  end

  assign span_o.valid        = out_valid_q;
  assign span_o.span_first_x = out_first_q;
  assign span_o.span_last_x  = out_last_q;
  assign span_o.span_y       = out_y_q;
  assign span_o.span_color   = out_color_q;
  assign span_o.last_of_item = out_lst_q;

endmodule

FILE: verif/tb_scanline_run_span_extractor_core.sv
`timescale 1ns / 100ps
// Testbench for scanline_run_span_extractor_core: pixels in, spans checked against a predictor.
// Depends on srse_pkg, the pixel/span/config channel interfaces and the core RTL.
module tb_scanline_run_span_extractor_core;
  import srse_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;
  localparam int IdlePct     = 23;

  typedef struct packed {
    logic [XW-1:0] first_x;
    logic [XW-1:0] last_x;
    logic [YW-1:0] y;
    logic [CW-1:0] color;
    logic          last_of_item;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srse_pix_if  pix_if ();
  srse_span_if span_if ();
  srse_cfg_if  cfg_if ();

  scanline_run_span_extractor_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .span_o (span_if),
    .cfg_i  (cfg_if)
  );

  // Register copies, as written through the config port
  logic [CW-1:0] shadow_bg      = '0;
  logic [SW-1:0] shadow_stretch = 4'd1;
  logic [SW-1:0] shadow_repeat  = 4'd1;
  logic [XW-1:0] shadow_first   = '0;
  logic [XW-1:0] shadow_last    = 10'd1023;

  // Row tracking state
  logic [XW:0]   run_next_x  = '0;
  logic [XW-1:0] run_start_x = '0;
  logic [CW-1:0] run_color   = '0;
  logic          run_open    = 1'b0;

  span_t pending_spans[$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  bit    steady_flow    = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Queue repeat_y spans of one finished run unless it is background
  task automatic queue_run_spans(input logic [XW-1:0] first_x, input logic [XW-1:0] last_x,
                                 input logic [YW-1:0] row, input logic [CW-1:0] color);
    int          reps;
    logic [YW:0] yy;
    span_t       s;
    if (color == shadow_bg) return;
    reps = (shadow_repeat == 0) ? 1 :
           ((shadow_repeat > MaxRepeat) ? MaxRepeat : int'(shadow_repeat));
    for (int k = 0; k < reps; k++) begin
      yy = row + k;
      s.first_x      = first_x;
      s.last_x       = last_x;
      s.y            = (yy > YMax) ? YMax : yy[YW-1:0];
      s.color        = color;
      s.last_of_item = 1'b0;
      pending_spans.push_back(s);
    end
  endtask

  // Advance the row tracker by one accepted pixel
  task automatic track_pixel(input logic [CW-1:0] color, input logic [YW-1:0] row);
    int          stretch;
    int          span_base;
    logic [XW:0] x0;
    logic [XW:0] x1;
    span_base = pending_spans.size();
    stretch   = (shadow_stretch == 0) ? 1 :
                ((shadow_stretch > MaxStretch) ? MaxStretch : int'(shadow_stretch));
    x0 = run_next_x;
    // Column already past the drawn area: drop, discard the run, restart the row
    if (x0 > {1'b0, shadow_last}) begin
      run_next_x  = {1'b0, shadow_first};
      run_start_x = shadow_first;
      run_open    = 1'b0;
      return;
    end
    x1 = x0 + (XW+1)'(stretch) - (XW+1)'(1);
    if (x1 > {1'b0, shadow_last}) x1 = {1'b0, shadow_last};
    if (run_open && color != run_color) begin
      queue_run_spans(run_start_x, x0[XW-1:0] - 1'b1, row, run_color);
      run_open = 1'b0;
    end
    if (!run_open) begin
      run_start_x = x0[XW-1:0];
      run_color   = color;
      run_open    = 1'b1;
    end
    run_next_x = x1 + (XW+1)'(1);
    // Row end closes the run
    if (x1 == {1'b0, shadow_last}) begin
      queue_run_spans(run_start_x, shadow_last, row, run_color);
      run_next_x  = {1'b0, shadow_first};
      run_start_x = shadow_first;
      run_open    = 1'b0;
    end
    if (pending_spans.size() > span_base) pending_spans[$].last_of_item = 1'b1;
  endtask

  // Send one pixel request; returns at the falling edge after acceptance
  task automatic send_pixel(input logic [CW-1:0] color, input logic [YW-1:0] row);
    while (!steady_flow && $urandom_range(99) < IdlePct) @(negedge clk_i);
    pix_if.valid       = 1'b1;
    pix_if.pixel_color = color;
    pix_if.row_y       = row;
    do @(posedge clk_i); while (!pix_if.ready);
    track_pixel(color, row);
    @(negedge clk_i);
    pix_if.valid = 1'b0;
  endtask

  // Write one register; upper data bits of narrow registers carry noise
  task automatic write_reg(input cfg_reg_e idx, input logic [XW-1:0] value);
    logic [XW-1:0] wdata;
    wdata = value;
    case (idx)
      REG_BACKGROUND_COLOR: wdata[XW-1:CW] = $urandom_range(0, 127);
      REG_STRETCH_X, REG_REPEAT_Y: wdata[XW-1:SW] = $urandom_range(0, 63);
      default: ;
    endcase
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = wdata;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_BACKGROUND_COLOR: shadow_bg      = wdata[CW-1:0];
      REG_STRETCH_X:        shadow_stretch = wdata[SW-1:0];
      REG_REPEAT_Y:         shadow_repeat  = wdata[SW-1:0];
      REG_ROW_FIRST_X:      shadow_first   = wdata;
      REG_ROW_LAST_X:       shadow_last    = wdata;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Wait for all expected spans, then for pixels still in flight
  task automatic wait_idle();
    while (pending_spans.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // Span sink: random stalls except during steady flow
  initial begin
    span_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      span_if.ready = steady_flow || ($urandom_range(99) >= IdlePct);
    end
  end

  // Compare every accepted span with the oldest expectation
  always @(posedge clk_i) begin
    span_t got;
    span_t want;
    if (rst_ni && span_if.valid && span_if.ready) begin
      got = '{span_if.span_first_x, span_if.span_last_x, span_if.span_y,
              span_if.span_color, span_if.last_of_item};
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span, expected none, actual %p", $time, got);
        mismatch_count++;
      end else begin
        want = pending_spans.pop_front();
        if (got.first_x !== want.first_x) report_field("span_first_x", want.first_x, got.first_x);
        if (got.last_x !== want.last_x) report_field("span_last_x", want.last_x, got.last_x);
        if (got.y !== want.y) report_field("span_y", want.y, got.y);
        if (got.color !== want.color) report_field("span_color", want.color, got.color);
        if (got.last_of_item !== want.last_of_item)
          report_field("last_of_item", want.last_of_item, got.last_of_item);
      end
    end
  end

  // Reset configuration: merge equal pixels, split on colour change
  task automatic test_default_runs();
    send_pixel(3'd7, 10'd0);
    send_pixel(3'd7, 10'd0);
    send_pixel(3'd1, 10'd0);
    send_pixel(3'd0, 10'd0);
  endtask

  // Clip at the last column, empty area, and a row cut short by a register change
  task automatic test_clip_and_drop();
    wait_idle();
    write_reg(REG_STRETCH_X, 10'd8);
    write_reg(REG_ROW_LAST_X, 10'd5);
    send_pixel(3'd2, 10'd1023);
    wait_idle();
    write_reg(REG_ROW_FIRST_X, 10'd20);
    send_pixel(3'd4, 10'd512);
    send_pixel(3'd5, 10'd512);
    send_pixel(3'd6, 10'd512);
    wait_idle();
    write_reg(REG_ROW_LAST_X, 10'd100);
    send_pixel(3'd3, 10'd7);
    send_pixel(3'd3, 10'd7);
    wait_idle();
    write_reg(REG_ROW_FIRST_X, 10'd1000);
    write_reg(REG_ROW_LAST_X, 10'd30);
    send_pixel(3'd1, 10'd7);
  endtask

  // Stretch and repeat above range, two runs closed by one pixel, span row saturation
  task automatic test_double_run_saturation();
    wait_idle();
    write_reg(REG_STRETCH_X, 10'd15);
    write_reg(REG_REPEAT_Y, 10'd15);
    write_reg(REG_ROW_LAST_X, 10'd1023);
    send_pixel(3'd7, 10'd1020);
    send_pixel(3'd7, 10'd1020);
    send_pixel(3'd3, 10'd1020);
  endtask

  // Stretch and repeat of zero, background colour suppression
  task automatic test_zero_and_background();
    wait_idle();
    write_reg(REG_STRETCH_X, 10'd0);
    write_reg(REG_REPEAT_Y, 10'd0);
    write_reg(REG_BACKGROUND_COLOR, 10'd5);
    write_reg(REG_ROW_FIRST_X, 10'd10);
    write_reg(REG_ROW_LAST_X, 10'd13);
    send_pixel(3'd5, 10'd300);
    send_pixel(3'd5, 10'd300);
    send_pixel(3'd5, 10'd300);
    send_pixel(3'd2, 10'd300);
    send_pixel(3'd5, 10'd300);
  endtask

  // Random configurations with runs of random length and occasional row jumps
  task automatic test_random_rows();
    logic [XW-1:0] first;
    logic [XW-1:0] last;
    logic [CW-1:0] color;
    logic [YW-1:0] row;
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      steady_flow = (phase == 5);
      write_reg(REG_BACKGROUND_COLOR, $urandom_range(0, 7));
      write_reg(REG_STRETCH_X, ($urandom_range(99) < 15) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 8));
      write_reg(REG_REPEAT_Y, ($urandom_range(99) < 10) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 3));
      first = $urandom_range(0, 1023);
      if ($urandom_range(99) < 8 && first > 0) last = $urandom_range(0, first - 1);
      else if ($urandom_range(99) < 8) last = 10'd1023;
      else last = ((first + $urandom_range(0, 60)) > 1023) ? 10'd1023
                                                           : first + $urandom_range(0, 60);
      write_reg(REG_ROW_FIRST_X, first);
      write_reg(REG_ROW_LAST_X, last);
      color = $urandom_range(0, 7);
      row   = $urandom_range(0, 1023);
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(99) < 35) color = $urandom_range(0, 7);
        if ($urandom_range(99) < 8)
          row = ($urandom_range(99) < 25) ? $urandom_range(1000, 1023) : $urandom_range(0, 1023);
        send_pixel(color, row);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni             = 1'b0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_color = '0;
    pix_if.row_y       = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_runs();
    test_clip_and_drop();
    test_double_run_saturation();
    test_zero_and_background();
    test_random_rows();

    wait_idle();
    if (mismatch_count == 0 && pending_spans.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/srse_pkg.sv
design/srse_pix_if.sv
design/srse_span_if.sv
design/srse_cfg_if.sv
design/srse_front.sv
design/srse_queue.sv
design/srse_back.sv
design/scanline_run_span_extractor_core.sv
verif/tb_scanline_run_span_extractor_core.sv
